FILE: src/cif_pkg.sv
// ----------------------------------------------------------------------------
// cif_pkg: shared types and constants for the color index flood fill block
// Holds defaults, command encodings, status codes and the queue entry format.
// ----------------------------------------------------------------------------
package cif_pkg;

	localparam int CANVAS_WIDTH_DEF  = 32;
	localparam int CANVAS_HEIGHT_DEF = 32;
	localparam int STACK_ENTRIES_DEF = 1024;
	localparam int INDEX_BITS_DEF    = 4;

	// The largest canvas is 64 by 64, so a cell number fits in 12 bits.
	localparam int PIX_ADDR_W  = 12;
	localparam int COORD_W     = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;

	typedef enum logic [1:0] {
		ST_ACCESS    = 2'd0,
		ST_FILL_DONE = 2'd1,
		ST_SAME      = 2'd2,
		ST_IGNORED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_WRITE  = 2'd0,
		K_READ   = 2'd1,
		K_FILL   = 2'd2,
		K_IGNORE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_READ,
		BS_SEED,
		BS_POP,
		BS_ENTRY,
		BS_PIX,
		BS_PUSH
	} back_state_t;

	typedef struct packed {
		kind_t                  kind;
		logic [PIX_ADDR_W-1:0]  pix_addr;
		logic [5:0]             x;
		logic [5:0]             y;
		logic [3:0]             color;
	} cmd_t;

endpackage

FILE: src/cif_if.sv
// ----------------------------------------------------------------------------
// cif_if: request and response channels of the color index flood fill block
// Each channel carries valid, ready and its payload fields.
// ----------------------------------------------------------------------------
interface cif_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [5:0] x_coord;
	logic [5:0] y_coord;
	logic [3:0] color_value;

	modport source (output valid, opcode, x_coord, y_coord, color_value, input ready);
	modport sink (input valid, opcode, x_coord, y_coord, color_value, output ready);
endinterface

interface cif_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] read_color;
	logic [1:0] status;

	modport source (output valid, read_color, status, input ready);
	modport sink (input valid, read_color, status, output ready);
endinterface

FILE: src/cif_front.sv
// ----------------------------------------------------------------------------
// cif_front: request decoder
// Checks bounds and opcode, computes the cell number and forms a queue entry.
// ----------------------------------------------------------------------------
module cif_front #(
	parameter int CANVAS_WIDTH  = cif_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = cif_pkg::CANVAS_HEIGHT_DEF
) (
	cif_req_if.sink         req,
	input  logic            clearing,
	output logic            push_valid,
	input  logic            push_ready,
	output cif_pkg::cmd_t   push_cmd
);

	logic x_in;
	logic y_in;

	assign x_in = {1'b0, req.x_coord} < 7'(CANVAS_WIDTH);
	assign y_in = {1'b0, req.y_coord} < 7'(CANVAS_HEIGHT);

	// No beat is taken while the pixel store is being initialized.
	assign req.ready  = push_ready && !clearing;
	assign push_valid = req.valid && !clearing;

	always_comb begin
		push_cmd.x        = req.x_coord;
		push_cmd.y        = req.y_coord;
		push_cmd.color    = req.color_value;
		push_cmd.pix_addr = cif_pkg::PIX_ADDR_W'(32'(req.y_coord) * 32'(CANVAS_WIDTH)
			+ 32'(req.x_coord));
		if (!(x_in && y_in)) begin
			push_cmd.kind = cif_pkg::K_IGNORE;
		end else begin
			case (req.opcode)
				cif_pkg::OP_WRITE: push_cmd.kind = cif_pkg::K_WRITE;
				cif_pkg::OP_READ:  push_cmd.kind = cif_pkg::K_READ;
				cif_pkg::OP_FILL:  push_cmd.kind = cif_pkg::K_FILL;
				default:           push_cmd.kind = cif_pkg::K_IGNORE;
			endcase
		end
	end

endmodule

FILE: src/cif_queue.sv
// ----------------------------------------------------------------------------
// cif_queue: short command queue
// Decouples the decoder from the execution engine so each can stall alone.
// ----------------------------------------------------------------------------
module cif_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  cif_pkg::cmd_t   push_cmd,
	output logic            pop_valid,
	input  logic            pop_ready,
	output cif_pkg::cmd_t   pop_cmd
);

	localparam int PW = (cif_pkg::QUEUE_DEPTH > 1) ? $clog2(cif_pkg::QUEUE_DEPTH) : 1;

	cif_pkg::cmd_t    entry_q [cif_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = count_q != (PW+1)'(cif_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PW'(cif_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PW'(cif_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: src/cif_back.sv
// ----------------------------------------------------------------------------
// cif_back: execution engine
// Owns the pixel store and the coordinate stack, runs accesses and fills,
// and holds the response in an output register.
// ----------------------------------------------------------------------------
module cif_back #(
	parameter int CANVAS_WIDTH  = cif_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = cif_pkg::CANVAS_HEIGHT_DEF,
	parameter int STACK_ENTRIES = cif_pkg::STACK_ENTRIES_DEF,
	parameter int INDEX_BITS    = cif_pkg::INDEX_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  cif_pkg::cmd_t   pop_cmd,
	output logic            clearing,
	cif_rsp_if.source       rsp
);

	localparam int PIXELS = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int PAW    = $clog2(PIXELS);
	localparam int SAW    = $clog2(STACK_ENTRIES);
	localparam int LW     = $clog2(STACK_ENTRIES + 1);
	localparam int IB     = INDEX_BITS;
	localparam int CW     = cif_pkg::COORD_W;

	cif_pkg::back_state_t state_q, state_d;
	logic [PAW-1:0]   clr_addr_q, clr_addr_d;
	logic [LW-1:0]    lvl_q, lvl_d;
	logic [1:0]       push_cnt_q, push_cnt_d;
	logic [IB-1:0]    seed_q, seed_d;
	logic [IB-1:0]    new_q, new_d;
	logic [CW-1:0]    cx_q, cx_d;
	logic [CW-1:0]    cy_q, cy_d;
	logic [PAW-1:0]   cell_q, cell_d;

	logic             out_valid_q;
	logic [3:0]       out_color_q;
	cif_pkg::status_t out_status_q;
	logic             out_load;
	logic [3:0]       out_color_d;
	cif_pkg::status_t out_status_d;
	logic             out_free;

	logic [IB-1:0]    pix_mem [PIXELS];
	logic [IB-1:0]    pix_rd_q;
	logic             pix_we;
	logic [PAW-1:0]   pix_waddr;
	logic [IB-1:0]    pix_wdata;
	logic             pix_re;
	logic [PAW-1:0]   pix_raddr;

	logic [2*CW-1:0]  stk_mem [STACK_ENTRIES];
	logic [2*CW-1:0]  stk_rd_q;
	logic             stk_we;
	logic [SAW-1:0]   stk_waddr;
	logic [2*CW-1:0]  stk_wdata;
	logic             stk_re;
	logic [SAW-1:0]   stk_raddr;

	logic [CW-1:0]    ent_x;
	logic [CW-1:0]    ent_y;
	logic             ent_in;
	logic [PAW-1:0]   ent_cell;
	logic             room4;

	// A popped entry holds the row in the upper half and the column in the lower.
	assign ent_x    = stk_rd_q[CW-1:0];
	assign ent_y    = stk_rd_q[2*CW-1:CW];
	assign ent_in   = (ent_x < CW'(CANVAS_WIDTH)) && (ent_y < CW'(CANVAS_HEIGHT));
	assign ent_cell = PAW'(32'(ent_y) * 32'(CANVAS_WIDTH) + 32'(ent_x));
	assign room4    = ((LW+1)'(lvl_q) + (LW+1)'(4)) <= (LW+1)'(STACK_ENTRIES);

	assign out_free = !out_valid_q || rsp.ready;
	assign clearing = state_q == cif_pkg::BS_CLEAR;

	always_comb begin
		state_d      = state_q;
		clr_addr_d   = clr_addr_q;
		lvl_d        = lvl_q;
		push_cnt_d   = push_cnt_q;
		seed_d       = seed_q;
		new_d        = new_q;
		cx_d         = cx_q;
		cy_d         = cy_q;
		cell_d       = cell_q;
		pop_ready    = 1'b0;
		out_load     = 1'b0;
		out_color_d  = '0;
		out_status_d = cif_pkg::ST_ACCESS;
		pix_we       = 1'b0;
		pix_waddr    = cell_q;
		pix_wdata    = new_q;
		pix_re       = 1'b0;
		pix_raddr    = cell_q;
		stk_we       = 1'b0;
		stk_waddr    = lvl_q[SAW-1:0];
		stk_wdata    = {cy_q, cx_q};
		stk_re       = 1'b0;
		stk_raddr    = SAW'(lvl_q - 1'b1);

		case (state_q)
			cif_pkg::BS_CLEAR: begin
				pix_we     = 1'b1;
				pix_waddr  = clr_addr_q;
				pix_wdata  = IB'(1);
				clr_addr_d = clr_addr_q + 1'b1;
				if (clr_addr_q == PAW'(PIXELS - 1)) begin
					state_d = cif_pkg::BS_IDLE;
				end
			end
			cif_pkg::BS_IDLE: begin
				if (pop_valid && out_free) begin
					pop_ready = 1'b1;
					cell_d    = pop_cmd.pix_addr[PAW-1:0];
					case (pop_cmd.kind)
						cif_pkg::K_WRITE: begin
							pix_we    = 1'b1;
							pix_waddr = pop_cmd.pix_addr[PAW-1:0];
							pix_wdata = IB'(pop_cmd.color);
							out_load  = 1'b1;
						end
						cif_pkg::K_READ: begin
							pix_re    = 1'b1;
							pix_raddr = pop_cmd.pix_addr[PAW-1:0];
							state_d   = cif_pkg::BS_READ;
						end
						cif_pkg::K_FILL: begin
							pix_re    = 1'b1;
							pix_raddr = pop_cmd.pix_addr[PAW-1:0];
							cx_d      = {1'b0, pop_cmd.x};
							cy_d      = {1'b0, pop_cmd.y};
							new_d     = IB'(pop_cmd.color);
							state_d   = cif_pkg::BS_SEED;
						end
						default: begin
							out_load     = 1'b1;
							out_status_d = cif_pkg::ST_IGNORED;
						end
					endcase
				end
			end
			cif_pkg::BS_READ: begin
				out_load    = 1'b1;
				out_color_d = 4'(pix_rd_q);
				state_d     = cif_pkg::BS_IDLE;
			end
			cif_pkg::BS_SEED: begin
				seed_d = pix_rd_q;
				if (pix_rd_q == new_q) begin
					out_load     = 1'b1;
					out_status_d = cif_pkg::ST_SAME;
					state_d      = cif_pkg::BS_IDLE;
				end else begin
					stk_we    = 1'b1;
					stk_waddr = '0;
					lvl_d     = LW'(1);
					state_d   = cif_pkg::BS_POP;
				end
			end
			cif_pkg::BS_POP: begin
				if (lvl_q == '0) begin
					out_load     = 1'b1;
					out_status_d = cif_pkg::ST_FILL_DONE;
					state_d      = cif_pkg::BS_IDLE;
				end else begin
					lvl_d   = lvl_q - 1'b1;
					stk_re  = 1'b1;
					state_d = cif_pkg::BS_ENTRY;
				end
			end
			cif_pkg::BS_ENTRY: begin
				cx_d = ent_x;
				cy_d = ent_y;
				if (ent_in) begin
					pix_re    = 1'b1;
					pix_raddr = ent_cell;
					cell_d    = ent_cell;
					state_d   = cif_pkg::BS_PIX;
				end else begin
					state_d = cif_pkg::BS_POP;
				end
			end
			cif_pkg::BS_PIX: begin
				state_d = cif_pkg::BS_POP;
				if (pix_rd_q == seed_q) begin
					pix_we = 1'b1;
					// Neighbors are dropped when fewer than four free slots remain.
					if (room4) begin
						push_cnt_d = '0;
						state_d    = cif_pkg::BS_PUSH;
					end
				end
			end
			cif_pkg::BS_PUSH: begin
				stk_we     = 1'b1;
				lvl_d      = lvl_q + 1'b1;
				push_cnt_d = push_cnt_q + 1'b1;
				// Pushed right, left, down, up, so up comes off the stack first.
				case (push_cnt_q)
					2'd0:    stk_wdata = {cy_q, cx_q + 1'b1};
					2'd1:    stk_wdata = {cy_q, cx_q - 1'b1};
					2'd2:    stk_wdata = {cy_q + 1'b1, cx_q};
					default: stk_wdata = {cy_q - 1'b1, cx_q};
				endcase
				if (push_cnt_q == 2'd3) begin
					state_d = cif_pkg::BS_POP;
				end
			end
			default: begin
				state_d = cif_pkg::BS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cif_pkg::BS_CLEAR;
			clr_addr_q  <= '0;
			lvl_q       <= '0;
			push_cnt_q  <= '0;
			seed_q      <= '0;
			new_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_addr_q <= clr_addr_d;
			lvl_q      <= lvl_d;
			push_cnt_q <= push_cnt_d;
			seed_q     <= seed_d;
			new_q      <= new_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cx_q   <= cx_d;
		cy_q   <= cy_d;
		cell_q <= cell_d;
		if (out_load) begin
			out_color_q  <= out_color_d;
			out_status_q <= out_status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[pix_waddr] <= pix_wdata;
		end
		if (pix_re) begin
			pix_rd_q <= pix_mem[pix_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_raddr];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_color = out_color_q;
	assign rsp.status     = out_status_q;

	a_idle_stack_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cif_pkg::BS_IDLE |-> lvl_q == '0)
		else $error("stack not empty between commands");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LW'(STACK_ENTRIES))
		else $error("stack level beyond capacity");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cif_pkg::BS_PUSH |-> lvl_q < LW'(STACK_ENTRIES))
		else $error("push into a full stack");

	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop_ready)
		else $error("command taken during store initialization");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("response overwrites one not yet taken");

endmodule

FILE: src/color_index_flood_fill.sv
// ----------------------------------------------------------------------------
// color_index_flood_fill: palette index canvas with 4-connected flood fill
// Writes and reads single pixels and fills connected regions from a seed.
// ----------------------------------------------------------------------------
// Channel  Role    Beat contents
// req      sink    opcode, x_coord, y_coord, color_value
// rsp      source  read_color, status
//
// After reset the store is initialized one pixel per cycle; req is held
// off until it ends. In the engine a write or an ignored request is done
// as it is taken; a read, and a fill whose color matches the seed, first
// read the pixel store. Any other fill pushes the seed and then, per popped
// stack entry, reads the entry, drops it if it lies off the canvas, else
// reads its pixel and, if that matches the seed color, recolors it and
// pushes its four neighbors one at a time when they fit; the single stack
// and pixel ports set this order. The engine takes a command only when the
// response register is free, so a stalled response holds it off.
// A two-entry queue takes requests while the engine is busy, and the
// response register takes a new beat in the cycle its old one leaves.
// ----------------------------------------------------------------------------
module color_index_flood_fill #(
	parameter int CANVAS_WIDTH  = cif_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = cif_pkg::CANVAS_HEIGHT_DEF,
	parameter int STACK_ENTRIES = cif_pkg::STACK_ENTRIES_DEF,
	parameter int INDEX_BITS    = cif_pkg::INDEX_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cif_req_if.sink    req,
	cif_rsp_if.source  rsp
);

	logic           clearing;
	logic           push_valid;
	logic           push_ready;
	cif_pkg::cmd_t  push_cmd;
	logic           pop_valid;
	logic           pop_ready;
	cif_pkg::cmd_t  pop_cmd;

	cif_front #(
		.CANVAS_WIDTH  (CANVAS_WIDTH),
		.CANVAS_HEIGHT (CANVAS_HEIGHT)
	) u_front (
		.req        (req),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	cif_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	cif_back #(
		.CANVAS_WIDTH  (CANVAS_WIDTH),
		.CANVAS_HEIGHT (CANVAS_HEIGHT),
		.STACK_ENTRIES (STACK_ENTRIES),
		.INDEX_BITS    (INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.clearing  (clearing),
		.rsp       (rsp)
	);

endmodule
